// ===== hw/rtl/rgb_window_min_max_filter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the window min/max filter RTL.
// ----------------------------------------------------------------------------
`ifndef RGB_WINDOW_MIN_MAX_FILTER_ASSERT_SVH
`define RGB_WINDOW_MIN_MAX_FILTER_ASSERT_SVH

// Property checked at every clock edge outside reset
`define RWMM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Trigger in one cycle implies consequence in the next
`define RWMM_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rwmm_pkg.sv =====
// ----------------------------------------------------------------------------
// rwmm_pkg
// Types, constants and codes shared by the window min/max filter modules.
// ----------------------------------------------------------------------------
package rwmm_pkg;

	localparam int unsigned MAX_WIDTH   = 1024;
	localparam int unsigned MAX_RADIUS  = 7;
	localparam int unsigned WIN_SPAN    = 2 * MAX_RADIUS + 1;
	localparam int unsigned STORE_DEPTH = MAX_WIDTH * WIN_SPAN;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
	localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
	localparam int unsigned WIDTH_W     = COL_W + 1;
	localparam int unsigned ROW_W       = 16;
	localparam int unsigned RAD_W       = $clog2(MAX_RADIUS + 1);
	localparam int unsigned OFS_W       = $clog2(WIN_SPAN);
	localparam int unsigned IDX_W       = ROW_W + COL_W;
	localparam int unsigned PIX_W       = 24;

	// opcodes
	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// filter modes
	localparam logic MODE_MIN = 1'b0;
	localparam logic MODE_MAX = 1'b1;

	// register indexes
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WSIZE  = 2'd1;
	localparam logic [1:0] REG_WIDTH  = 2'd2;
	localparam logic [1:0] REG_HEIGHT = 2'd3;

	typedef struct packed {
		logic       opcode;
		logic [7:0] chan_a;
		logic [7:0] chan_b;
		logic [7:0] chan_c;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] res_a;
		logic [7:0] res_b;
		logic [7:0] res_c;
		logic       frame_last;
	} out_beat_t;

	// store access request into the address unit
	typedef struct packed {
		logic             valid;
		logic             wr;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} addr_req_t;

	// resolved store address out of the address unit
	typedef struct packed {
		logic              valid;
		logic              wr;
		logic              busy;
		logic [ADDR_W-1:0] addr;
	} addr_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_CHECK,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

endpackage

// ===== hw/rtl/rwmm_addr.sv =====
// ----------------------------------------------------------------------------
// rwmm_addr
// Two-stage address unit: raster index row*width+col, then modulo store depth.
// ----------------------------------------------------------------------------
module rwmm_addr (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rwmm_pkg::addr_req_t              req,
	input  logic [rwmm_pkg::WIDTH_W-1:0]     width,
	output rwmm_pkg::addr_rsp_t              rsp
);

	localparam int unsigned PROD_W = rwmm_pkg::ROW_W + rwmm_pkg::WIDTH_W;
	localparam int unsigned HI_W   = rwmm_pkg::IDX_W - rwmm_pkg::COL_W;

	logic                          valid_s2, wr_s2;
	logic [rwmm_pkg::IDX_W-1:0]    idx_s2;
	logic                          valid_s3, wr_s3;
	logic [rwmm_pkg::ADDR_W-1:0]   addr_s3;
	logic [PROD_W-1:0]             prod;
	logic [HI_W-1:0]               hi;
	logic [5:0]                    fold1;
	logic [4:0]                    fold2;
	logic [3:0]                    rowmod;

	// raster index
	assign prod = PROD_W'(req.row) * PROD_W'(width) + PROD_W'(req.col);

	// depth is 15 blocks of 1024: low bits pass, the block number is taken
	// mod 15 by folding hex digits (16 = 1 mod 15)
	assign hi     = idx_s2[rwmm_pkg::IDX_W-1:rwmm_pkg::COL_W];
	assign fold1  = 6'(hi[3:0]) + 6'(hi[7:4]) + 6'(hi[11:8]) + 6'(hi[15:12]);
	assign fold2  = 5'(fold1[5:4]) + 5'(fold1[3:0]);
	assign rowmod = (fold2 >= 5'd15) ? 4'(fold2 - 5'd15) : fold2[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= req.valid;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		wr_s2   <= req.wr;
		idx_s2  <= prod[rwmm_pkg::IDX_W-1:0];
		wr_s3   <= wr_s2;
		addr_s3 <= {rowmod, idx_s2[rwmm_pkg::COL_W-1:0]};
	end

	assign rsp.valid = valid_s3;
	assign rsp.wr    = wr_s3;
	assign rsp.busy  = valid_s2 | valid_s3;
	assign rsp.addr  = addr_s3;

endmodule

// ===== hw/rtl/rwmm_lane.sv =====
// ----------------------------------------------------------------------------
// rwmm_lane
// One color channel lane: running minimum or maximum over the window.
// ----------------------------------------------------------------------------
module rwmm_lane (
	input  logic       clk,
	input  logic       init,
	input  logic       en,
	input  logic       mode,
	input  logic [7:0] din,
	output logic [7:0] acc
);

	logic [7:0] acc_q;
	logic       take;

	assign take = (mode == rwmm_pkg::MODE_MAX) ? (din > acc_q) : (din < acc_q);

	// init loads the identity of the selected operation
	always_ff @(posedge clk) begin
		if (init) begin
			acc_q <= (mode == rwmm_pkg::MODE_MAX) ? 8'd0 : 8'd255;
		end else if (en && take) begin
			acc_q <= din;
		end
	end

	assign acc = acc_q;

endmodule

// ===== hw/rtl/rgb_window_min_max_filter.sv =====
// ----------------------------------------------------------------------------
// rgb_window_min_max_filter
// Per-channel erosion/dilation of a raster RGB stream with mirrored borders.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and are kept in a single-port store of
// 15 rows of up to 1024 pixels; each result is the per-channel minimum or
// maximum over a (2R+1)x(2R+1) window, R = window_size/2. One item is worked
// at a time: a beat is accepted in the idle state, a push then writes the
// store through the address pipeline, and the readiness check follows; a
// drain, or a push past the frame end, skips the write. An item that yields
// a result then reads its (2R+1)^2 window pixels from the store, one per
// cycle, waits for the read pipeline to empty and loads the output register;
// an item with no result returns to idle after the check. A stalled output
// holds the block in the emit state until the previous beat is taken. The
// store needs no clearing after reset.
// ----------------------------------------------------------------------------
module rgb_window_min_max_filter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rwmm_pkg::in_beat_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rwmm_pkg::out_beat_t  out_data
);

`include "rgb_window_min_max_filter_assert.svh"

	localparam int unsigned ROW_W  = rwmm_pkg::ROW_W;
	localparam int unsigned COL_W  = rwmm_pkg::COL_W;
	localparam int unsigned WID_W  = rwmm_pkg::WIDTH_W;
	localparam int unsigned RAD_W  = rwmm_pkg::RAD_W;
	localparam int unsigned OFS_W  = rwmm_pkg::OFS_W;
	localparam int unsigned MIR_W  = ROW_W + 3;

	// configuration registers
	logic              mode_q;
	logic [3:0]        wsize_q;
	logic [WID_W-1:0]  fwidth_q;
	logic [ROW_W-1:0]  fheight_q;

	// positions
	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [OFS_W-1:0]  kr_q, kc_q;
	logic [rwmm_pkg::PIX_W-1:0] pix_q;

	rwmm_pkg::state_t  state_q, state_d;

	logic              cfg_wr;
	logic [WID_W-1:0]  eff_w;
	logic [ROW_W-1:0]  eff_h;
	logic [3:0]        half;
	logic [RAD_W-1:0]  rad;
	logic [OFS_W-1:0]  span_m1;
	logic              accept, push_ok;
	logic              issue_wr, issue_rd, scan_init, load_out, out_free;
	logic              scan_end, pipe_busy, ready, last;
	logic [ROW_W:0]    h_m1, nr_raw, need_r;
	logic [WID_W-1:0]  w_m1, nc_raw, need_c, col_inc;
	logic [ROW_W-1:0]  mir_row, mir_col_full;

	rwmm_pkg::addr_req_t req_s1;
	rwmm_pkg::addr_rsp_t rsp;

	logic [rwmm_pkg::PIX_W-1:0] mem [rwmm_pkg::STORE_DEPTH];
	logic [rwmm_pkg::PIX_W-1:0] rdata_s4;
	logic                       rvalid_s4;
	logic [7:0]                 lane_acc [3];

	rwmm_pkg::out_beat_t out_q;
	logic                out_valid_q;

	// mirror with edge repeat, clamped into [0, n-1]
	function automatic logic [ROW_W-1:0] mirror_idx(input logic signed [MIR_W-1:0] i,
	                                                input logic [ROW_W:0] n);
		logic signed [MIR_W-1:0] v;
		logic signed [MIR_W-1:0] ns;
		begin
			ns = $signed(MIR_W'(n));
			v  = i;
			if (v < $signed(MIR_W'(0))) v = -v - $signed(MIR_W'(1));
			if (v >= ns) v = (ns <<< 1) - v - $signed(MIR_W'(1));
			if (v < $signed(MIR_W'(0))) v = $signed(MIR_W'(0));
			if (v >= ns) v = ns - $signed(MIR_W'(1));
			return v[ROW_W-1:0];
		end
	endfunction

	// ------------------------------------------------------------------
	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= rwmm_pkg::MODE_MIN;
			wsize_q   <= 4'd3;
			fwidth_q  <= WID_W'(640);
			fheight_q <= ROW_W'(480);
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				rwmm_pkg::REG_MODE:   mode_q    <= pwdata[0];
				rwmm_pkg::REG_WSIZE:  wsize_q   <= pwdata[3:0];
				rwmm_pkg::REG_WIDTH:  fwidth_q  <= pwdata[WID_W-1:0];
				rwmm_pkg::REG_HEIGHT: fheight_q <= pwdata[ROW_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			rwmm_pkg::REG_MODE:   prdata = {31'b0, mode_q};
			rwmm_pkg::REG_WSIZE:  prdata = {28'b0, wsize_q};
			rwmm_pkg::REG_WIDTH:  prdata = {{(32-WID_W){1'b0}}, fwidth_q};
			rwmm_pkg::REG_HEIGHT: prdata = {{(32-ROW_W){1'b0}}, fheight_q};
		endcase
	end

	// ------------------------------------------------------------------
	// Effective dimensions and radius
	always_comb begin
		if (fwidth_q == '0) eff_w = WID_W'(1);
		else if (fwidth_q > WID_W'(rwmm_pkg::MAX_WIDTH)) eff_w = WID_W'(rwmm_pkg::MAX_WIDTH);
		else eff_w = fwidth_q;
	end
	assign eff_h   = (fheight_q == '0) ? ROW_W'(1) : fheight_q;
	assign half    = {1'b0, wsize_q[3:1]};
	assign rad     = (half > 4'(rwmm_pkg::MAX_RADIUS)) ? RAD_W'(rwmm_pkg::MAX_RADIUS)
	                                                   : half[RAD_W-1:0];
	assign span_m1 = OFS_W'({rad, 1'b0});

	// ------------------------------------------------------------------
	// Readiness of the next output and frame end
	assign h_m1   = {1'b0, eff_h} - (ROW_W+1)'(1);
	assign w_m1   = eff_w - WID_W'(1);
	assign nr_raw = {1'b0, out_row_q} + (ROW_W+1)'(rad);
	assign nc_raw = {1'b0, out_col_q} + WID_W'(rad);
	assign need_r = (nr_raw > h_m1) ? h_m1 : nr_raw;
	assign need_c = (nc_raw > w_m1) ? w_m1 : nc_raw;
	assign ready  = (in_row_q >= eff_h) || (need_r < {1'b0, in_row_q})
	             || ((need_r == {1'b0, in_row_q}) && (need_c < {1'b0, in_col_q}));
	assign last   = ({1'b0, out_row_q} >= h_m1) && ({1'b0, out_col_q} >= w_m1);

	// ------------------------------------------------------------------
	// Sequencer
	assign accept   = in_valid & ~in_stall;
	assign push_ok  = (in_data.opcode == rwmm_pkg::OP_PUSH) && (in_row_q < eff_h);
	assign scan_end = (kr_q == span_m1) && (kc_q == span_m1);
	assign pipe_busy = req_s1.valid | rsp.busy | rvalid_s4;
	assign out_free = ~out_valid_q | ~out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rwmm_pkg::ST_IDLE:  if (in_valid) state_d = push_ok ? rwmm_pkg::ST_WRITE
			                                                    : rwmm_pkg::ST_CHECK;
			rwmm_pkg::ST_WRITE: if (!pipe_busy) state_d = rwmm_pkg::ST_CHECK;
			rwmm_pkg::ST_CHECK: state_d = ready ? rwmm_pkg::ST_SCAN : rwmm_pkg::ST_IDLE;
			rwmm_pkg::ST_SCAN:  if (scan_end) state_d = rwmm_pkg::ST_DRAIN;
			rwmm_pkg::ST_DRAIN: if (!pipe_busy) state_d = rwmm_pkg::ST_EMIT;
			rwmm_pkg::ST_EMIT:  if (out_free) state_d = rwmm_pkg::ST_IDLE;
			default:            state_d = rwmm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != rwmm_pkg::ST_IDLE);
		issue_wr  = (state_q == rwmm_pkg::ST_IDLE) && in_valid && push_ok;
		scan_init = (state_q == rwmm_pkg::ST_CHECK) && ready;
		issue_rd  = (state_q == rwmm_pkg::ST_SCAN);
		load_out  = (state_q == rwmm_pkg::ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rwmm_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// ------------------------------------------------------------------
	// Position counters
	assign col_inc = {1'b0, in_col_q} + WID_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (load_out && last) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (load_out) begin
			if ({1'b0, out_col_q} + WID_W'(1) >= eff_w) begin
				out_col_q <= '0;
				out_row_q <= out_row_q + ROW_W'(1);
			end else begin
				out_col_q <= out_col_q + COL_W'(1);
			end
		end else if (issue_wr && accept) begin
			if (col_inc >= eff_w) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + ROW_W'(1);
			end else begin
				in_col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	// window offsets, row-major
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kr_q <= '0;
			kc_q <= '0;
		end else if (scan_init) begin
			kr_q <= '0;
			kc_q <= '0;
		end else if (issue_rd) begin
			if (kc_q == span_m1) begin
				kc_q <= '0;
				kr_q <= kr_q + OFS_W'(1);
			end else begin
				kc_q <= kc_q + OFS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue_wr) pix_q <= {in_data.chan_c, in_data.chan_b, in_data.chan_a};
	end

	// ------------------------------------------------------------------
	// Window position, mirrored at the frame edges
	assign mir_row = mirror_idx($signed(MIR_W'(out_row_q)) + $signed(MIR_W'(kr_q))
	                            - $signed(MIR_W'(rad)), (ROW_W+1)'(eff_h));
	assign mir_col_full = mirror_idx($signed(MIR_W'(out_col_q)) + $signed(MIR_W'(kc_q))
	                                 - $signed(MIR_W'(rad)), (ROW_W+1)'(eff_w));

	// store request: pixel write or window read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else begin
			req_s1.valid <= issue_wr | issue_rd;
			req_s1.wr    <= issue_wr;
			req_s1.row   <= issue_wr ? in_row_q : mir_row;
			req_s1.col   <= issue_wr ? in_col_q : mir_col_full[COL_W-1:0];
		end
	end

	rwmm_addr u_addr (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_s1),
		.width  (eff_w),
		.rsp    (rsp)
	);

	// ------------------------------------------------------------------
	// Pixel store
	always_ff @(posedge clk) begin
		if (rsp.valid && rsp.wr) mem[rsp.addr] <= pix_q;
		rdata_s4 <= mem[rsp.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rvalid_s4 <= 1'b0;
		else rvalid_s4 <= rsp.valid & ~rsp.wr;
	end

	// ------------------------------------------------------------------
	// Channel lanes
	for (genvar k = 0; k < 3; k++) begin : g_lane
		rwmm_lane u_lane (
			.clk  (clk),
			.init (scan_init),
			.en   (rvalid_s4),
			.mode (mode_q),
			.din  (rdata_s4[8*k +: 8]),
			.acc  (lane_acc[k])
		);
	end

	// ------------------------------------------------------------------
	// Merge lanes into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (load_out) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.res_a      <= lane_acc[0];
			out_q.res_b      <= lane_acc[1];
			out_q.res_c      <= lane_acc[2];
			out_q.frame_last <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ------------------------------------------------------------------
	// Assertions
	`RWMM_ASSERT(a_store_wr_in_write, ((rsp.valid && rsp.wr) |-> (state_q == rwmm_pkg::ST_WRITE)), "store write outside write phase")
	`RWMM_ASSERT(a_emit_pipe_empty, ((state_q == rwmm_pkg::ST_EMIT) |-> !pipe_busy), "result emitted with reads in flight")
	`RWMM_ASSERT_NEXT(a_load_sets_valid, load_out, out_valid_q, "output load lost")
	`RWMM_ASSERT_NEXT(a_scan_exit, (state_q == rwmm_pkg::ST_SCAN), ((state_q == rwmm_pkg::ST_SCAN) || (state_q == rwmm_pkg::ST_DRAIN)), "scan left without drain")

endmodule
